// ----- hdl/rtr_pkg.sv -----
// shared types, constants and letter tables for the roman numeral encoder
package rtr_pkg;

	localparam int NUM_W      = 12;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = 4;
	localparam int LETTER_W   = 8;
	localparam int MAX_VALUE  = 3999;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LETTER_W-1:0] SYM_I    = 8'h49;
	localparam logic [LETTER_W-1:0] SYM_V    = 8'h56;
	localparam logic [LETTER_W-1:0] SYM_X    = 8'h58;
	localparam logic [LETTER_W-1:0] SYM_L    = 8'h4c;
	localparam logic [LETTER_W-1:0] SYM_C    = 8'h43;
	localparam logic [LETTER_W-1:0] SYM_D    = 8'h44;
	localparam logic [LETTER_W-1:0] SYM_M    = 8'h4d;
	localparam logic [LETTER_W-1:0] SYM_NONE = 8'h00;

	// digit positions
	localparam logic [1:0] POS_UNITS     = 2'd0;
	localparam logic [1:0] POS_TENS      = 2'd1;
	localparam logic [1:0] POS_HUNDREDS  = 2'd2;
	localparam logic [1:0] POS_THOUSANDS = 2'd3;

	typedef enum logic [1:0] {
		SEL_ONE,
		SEL_FIVE,
		SEL_TEN
	} sel_t;

	// one classified item on its way from front to back
	typedef struct packed {
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
		logic                               err;
	} entry_t;

	// digit at a given decimal scale, by a ladder of independent compares
	function automatic logic [DIGIT_W-1:0] digit_of(input logic [NUM_W-1:0] rem,
			input int scale);
		logic [DIGIT_W-1:0] d;
		d = '0;
		for (int i = 1; i <= 9; i++) begin
			if (int'(rem) >= i * scale) d = DIGIT_W'(i);
		end
		return d;
	endfunction

	function automatic logic [NUM_W-1:0] rem_after(input logic [NUM_W-1:0] rem,
			input logic [DIGIT_W-1:0] d, input int scale);
		return NUM_W'(int'(rem) - int'(d) * scale);
	endfunction

	// number of letters a digit turns into
	function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
		logic [2:0] n;
		case (d)
			4'd1, 4'd5:       n = 3'd1;
			4'd2, 4'd4, 4'd6,
			4'd9:             n = 3'd2;
			4'd3, 4'd7:       n = 3'd3;
			4'd8:             n = 3'd4;
			default:          n = 3'd0;
		endcase
		return n;
	endfunction

	// which symbol of the position the k-th letter of a digit uses
	function automatic sel_t digit_sel(input logic [DIGIT_W-1:0] d, input logic [1:0] k);
		sel_t s;
		case (d)
			4'd4:             s = (k == 2'd0) ? SEL_ONE : SEL_FIVE;
			4'd9:             s = (k == 2'd0) ? SEL_ONE : SEL_TEN;
			4'd5, 4'd6, 4'd7,
			4'd8:             s = (k == 2'd0) ? SEL_FIVE : SEL_ONE;
			default:          s = SEL_ONE;
		endcase
		return s;
	endfunction

	function automatic logic [LETTER_W-1:0] pos_sym(input logic [1:0] pos, input sel_t s);
		logic [LETTER_W-1:0] c;
		c = SYM_NONE;
		case (pos)
			POS_UNITS:    c = (s == SEL_ONE) ? SYM_I : (s == SEL_FIVE) ? SYM_V : SYM_X;
			POS_TENS:     c = (s == SEL_ONE) ? SYM_X : (s == SEL_FIVE) ? SYM_L : SYM_C;
			POS_HUNDREDS: c = (s == SEL_ONE) ? SYM_C : (s == SEL_FIVE) ? SYM_D : SYM_M;
			default:      c = (s == SEL_ONE) ? SYM_M : SYM_NONE;
		endcase
		return c;
	endfunction

	// highest non-zero digit position in a mask
	function automatic logic [1:0] top_pos(input logic [NUM_DIGITS-1:0] m);
		logic [1:0] p;
		if (m[3])      p = POS_THOUSANDS;
		else if (m[2]) p = POS_HUNDREDS;
		else if (m[1]) p = POS_TENS;
		else           p = POS_UNITS;
		return p;
	endfunction

endpackage

// ----- hdl/rtr_front.sv -----
// front end: takes an item, checks its range and splits it into decimal digits
module rtr_front
	import rtr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] number,
	output logic             busy,
	input  logic             full,
	output logic             push,
	output entry_t           entry
);

	typedef enum logic [1:0] {
		ST_THOU,
		ST_HUND,
		ST_TENS
	} step_t;

	logic                busy_q;
	step_t               step_q;
	logic [NUM_W-1:0]    rem_q;
	logic                err_q;
	logic [DIGIT_W-1:0]  thou_q;
	logic [DIGIT_W-1:0]  hund_q;

	logic [DIGIT_W-1:0]  dig;
	logic [NUM_W-1:0]    rem_next;
	logic [DIGIT_W-1:0]  units;

	always_comb begin
		case (step_q)
			ST_THOU: begin
				dig      = digit_of(rem_q, 1000);
				rem_next = rem_after(rem_q, dig, 1000);
			end
			ST_HUND: begin
				dig      = digit_of(rem_q, 100);
				rem_next = rem_after(rem_q, dig, 100);
			end
			default: begin
				dig      = digit_of(rem_q, 10);
				rem_next = rem_after(rem_q, dig, 10);
			end
		endcase
		units = rem_next[DIGIT_W-1:0];
	end

	assign busy         = busy_q;
	assign push         = busy_q && (step_q == ST_TENS) && !full;
	assign entry.digits = {thou_q, hund_q, dig, units};
	assign entry.err    = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ST_THOU;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= ST_THOU;
				rem_q  <= number;
				err_q  <= (number == '0) || (int'(number) > MAX_VALUE);
			end
		end else begin
			case (step_q)
				ST_THOU: begin
					thou_q <= dig;
					rem_q  <= rem_next;
					step_q <= ST_HUND;
				end
				ST_HUND: begin
					hund_q <= dig;
					rem_q  <= rem_next;
					step_q <= ST_TENS;
				end
				default: begin
					if (!full) begin
						busy_q <= 1'b0;
						step_q <= ST_THOU;
					end
				end
			endcase
		end
	end

endmodule

// ----- hdl/rtr_fifo.sv -----
// short queue of classified items between front and back
module rtr_fifo
	import rtr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output logic   valid,
	output entry_t rd_entry
);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/rtr_back.sv -----
// back end: walks the digits of an item and sends out one letter per cycle
module rtr_back
	import rtr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  entry_t              entry,
	output logic                pop,
	output logic                strobe,
	output logic [LETTER_W-1:0] letter,
	output logic                last,
	output logic                error
);

	logic                               active_q;
	logic [1:0]                         pos_q;
	logic [1:0]                         k_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic                               err_q;

	logic                strobe_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	logic                error_q;

	logic [DIGIT_W-1:0]    d;
	logic [2:0]            len;
	logic [NUM_DIGITS-1:0] nz;
	logic [NUM_DIGITS-1:0] nz_in;
	logic [NUM_DIGITS-1:0] below;
	logic                  digit_end;
	logic                  finish;
	logic [LETTER_W-1:0]   sym;

	always_comb begin
		d   = digits_q[pos_q];
		len = digit_len(d);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			nz[i]    = (digits_q[i] != '0);
			nz_in[i] = (entry.digits[i] != '0);
			below[i] = nz[i] && (i < int'(pos_q));
		end
		digit_end = ({1'b0, k_q} + 3'd1) >= len;
		finish    = active_q && (err_q || (digit_end && (below == '0)));
		sym       = err_q ? SYM_NONE : pos_sym(pos_q, digit_sel(d, k_q));
	end

	assign pop    = valid && (!active_q || finish);
	assign strobe = strobe_q;
	assign letter = letter_q;
	assign last   = last_q;
	assign error  = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			letter_q <= sym;
			last_q   <= finish;
			error_q  <= err_q;
			if (pop) begin
				active_q <= 1'b1;
				digits_q <= entry.digits;
				err_q    <= entry.err;
				pos_q    <= top_pos(nz_in);
				k_q      <= '0;
			end else if (finish) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (digit_end) begin
					pos_q <= top_pos(below);
					k_q   <= '0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/integer_to_roman_encoder_core.sv -----
// integer to roman numeral encoder, top level
//
// converts a 12-bit binary number into its roman numeral as ascii letters, one
// letter per strobe, most significant letter first, with last marking the final
// letter of each numeral. a number of 0 or above 3999 gives a single result
// with letter 0, last 1 and error 1. an item is taken on a clock edge with start
// high and busy low. the front end holds the item while it peels off the
// thousands, hundreds and tens digits, then hands it to a two-item queue; busy
// is high during those steps and while it waits on a full queue. the front end
// takes no new item until it has handed the last one to the queue. the back end
// sends one letter per cycle, with no gap between numerals as long as the queue
// holds the next one; a numeral has 1 to 15 letters (3888 is the longest).
// numerals of four letters or more run at the output rate, shorter ones at the
// front end's rate. when the queue is empty and the back end is idle, the first
// letter goes through the thousands, hundreds and tens steps, the queue and the
// back end's output register. results have no backpressure: each is on
// letter/last/error for exactly one cycle with strobe high and must be taken
// then. there is no state kept between numerals.
module integer_to_roman_encoder_core
	import rtr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_W-1:0]    number,
	output logic                busy,
	output logic                strobe,
	output logic [LETTER_W-1:0] letter,
	output logic                last,
	output logic                error
);

	// front to queue
	logic   q_push;
	logic   q_full;
	entry_t q_wr_entry;

	// queue to back
	logic   q_pop;
	logic   q_valid;
	entry_t q_rd_entry;

	// range check and digit split
	rtr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.number (number),
		.busy   (busy),
		.full   (q_full),
		.push   (q_push),
		.entry  (q_wr_entry)
	);

	// decouples digit split from letter output
	rtr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.rd_entry (q_rd_entry)
	);

	// letter sequencer, one letter a cycle while it holds an item, registered outputs
	rtr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (q_valid),
		.entry  (q_rd_entry),
		.pop    (q_pop),
		.strobe (strobe),
		.letter (letter),
		.last   (last),
		.error  (error)
	);

endmodule
